// ===== design/char_lcd_nibble_sequencer_defines.svh =====
// Assertion helpers used by the controller RTL.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

// Same-cycle implication.
`define CLNS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CLNS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/clns_pkg.sv =====
package clns_pkg;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_CMD    = 2'd1,
    MODE_CHAR   = 2'd2,
    MODE_CURSOR = 2'd3
  } mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_FUNCSET  = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF = 8'h08;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] ROW1_OFFSET  = 8'h40;

  localparam logic [3:0] NIB_WAKE     = 4'h3;
  localparam logic [3:0] NIB_4BIT     = 4'h2;
  localparam logic [5:0] POWER_UP_MS  = 6'd50;
  localparam logic [2:0] WAKE_AFTER_MS = 3'd6;

  // Pulse index bounds: init runs 0..13, the four wake nibbles are 0..3.
  localparam logic [3:0] IDX_INIT_LAST = 4'd13;
  localparam logic [3:0] IDX_FIRST_CMD = 4'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [5:0] column;
  } in_word_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic [5:0] wait_before_ms;
    logic [2:0] wait_after_ms;
    logic       last;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load_req;
    logic       load_out;
    logic [3:0] idx;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;
  } dp_sts_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] n);
    logic [7:0] c;
    case (n)
      3'd0:    c = CMD_FUNCSET;
      3'd1:    c = CMD_DISP_OFF;
      3'd2:    c = CMD_CLEAR;
      3'd3:    c = CMD_ENTRY;
      default: c = CMD_DISP_ON;
    endcase
    return c;
  endfunction

endpackage

// ===== design/clns_dp.sv =====
module clns_dp
  import clns_pkg::*;
(
  input  logic      clk_i,
  input  in_word_t  in_data_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output out_word_t out_data_o
);

  in_word_t   req_q;
  out_word_t  out_q;
  out_word_t  pulse;
  logic [7:0] byte_sel;
  logic [2:0] init_n;
  logic [3:0] cmd_idx;
  logic       low_half;
  logic       is_special;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    if (cmd_i.load_out) begin
      out_q <= pulse;
    end
  end

  always_comb begin
    cmd_idx  = cmd_i.idx - IDX_FIRST_CMD;
    init_n   = cmd_idx[3:1];
    // high nibble on even index in every mode (init commands start at 4)
    low_half = cmd_i.idx[0];
    case (mode_e'(req_q.mode))
      MODE_INIT: byte_sel = init_cmd(init_n);
      MODE_CMD,
      MODE_CHAR: byte_sel = req_q.byte_value;
      default: begin
        byte_sel = CMD_SET_DDRAM | ({2'b00, req_q.column} +
                   ((req_q.row != 2'd0) ? ROW1_OFFSET : 8'h00));
      end
    endcase
    is_special = (byte_sel == CMD_CLEAR) || (byte_sel == CMD_HOME);

    pulse.reg_select     = (mode_e'(req_q.mode) == MODE_CHAR);
    pulse.nibble         = low_half ? byte_sel[3:0] : byte_sel[7:4];
    pulse.wait_before_ms = 6'd0;
    if (!low_half) begin
      pulse.wait_after_ms = 3'd1;
    end else if (pulse.reg_select) begin
      pulse.wait_after_ms = 3'd3;
    end else if (is_special) begin
      pulse.wait_after_ms = 3'd4;
    end else begin
      pulse.wait_after_ms = 3'd2;
    end
    pulse.last = low_half;

    if (mode_e'(req_q.mode) == MODE_INIT) begin
      pulse.last = (cmd_i.idx == IDX_INIT_LAST);
      if (cmd_i.idx < IDX_FIRST_CMD) begin
        // wake-up run: three 0x3 nibbles then the 4-bit switch
        pulse.nibble         = (cmd_i.idx == 4'd3) ? NIB_4BIT : NIB_WAKE;
        pulse.wait_before_ms = (cmd_i.idx == 4'd0) ? POWER_UP_MS : 6'd0;
        pulse.wait_after_ms  = (cmd_i.idx == 4'd0) ? WAKE_AFTER_MS : 3'd2;
      end
    end
  end

  assign sts_o.last = pulse.last;
  assign out_data_o = out_q;

endmodule

// ===== design/clns_ctrl.sv =====
module clns_ctrl
  import clns_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

`include "char_lcd_nibble_sequencer_defines.svh"

  state_e     state_q, state_d;
  logic [3:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd_o.load_out && sts_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.load_req = 1'b0;
    cmd_o.load_out = 1'b0;
    cmd_o.idx      = idx_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      ST_RUN: begin
        cmd_o.load_out = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_o.load_req) begin
      idx_d = 4'd0;
    end else if (cmd_o.load_out && !sts_i.last) begin
      idx_d = idx_q + 4'd1;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `CLNS_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && in_ready_o,
    (state_q == ST_RUN) && (idx_q == 4'd0), "accepted word did not start a run")
  `CLNS_ASSERT_NOW(a_idx_bound, clk_i, rst_ni, state_q == ST_RUN,
    idx_q <= IDX_INIT_LAST, "pulse index past end of init run")
  `CLNS_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, cmd_o.load_out && sts_i.last,
    (state_q == ST_IDLE) && out_valid_q, "last pulse did not end the run")

endmodule

// ===== design/char_lcd_nibble_sequencer.sv =====
// Character LCD (HD44780-style, 4-bit bus) pulse sequencer. Each request word
// (init, command byte, character byte or set cursor) becomes a run of output
// words, one per enable pulse, each carrying RS, the D4..D7 nibble, the ms to
// wait before enable rises and after it falls, and a last flag. Bytes go out
// high nibble first: two words per request, fourteen for init. One output word
// leaves per cycle when the sink is ready, paced by the single pulse-index
// counter in the controller; a new request is taken once the final word of the
// previous one sits in the output register, in the idle accept state between
// requests.
module char_lcd_nibble_sequencer
  import clns_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  dp_cmd_t dp_cmd;  // load strobes and pulse index
  dp_sts_t dp_sts;  // current pulse ends the run

  // sequencing: handshakes, pulse index, output valid
  clns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // request register, pulse decode, output register
  clns_dp u_dp (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .out_data_o (out_data_o)
  );

endmodule
